/* design/sorted_timer_queue_defines.svh */
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define STQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define STQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define STQ_ASSERT(lbl, clk, rstn, prop, msg)
`define STQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

/* design/stq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Sizes, command and result kind codes, entry and control types, and cell operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int ActiveDepth   = 32;
  localparam int PendAddDepth  = 8;
  localparam int PendRmDepth   = 8;
  localparam int ClientIdBits  = 8;
  localparam int TimeBits      = 32;
  localparam int AddIdxW       = $clog2(PendAddDepth);
  localparam int RmIdxW        = $clog2(PendRmDepth);
  localparam int AddCntW       = $clog2(PendAddDepth + 1);
  localparam int RmCntW        = $clog2(PendRmDepth + 1);
  localparam int IdxW          = (AddIdxW > RmIdxW) ? AddIdxW : RmIdxW;

  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_REG_ONCE   = 2'd1;
  localparam logic [1:0] CMD_REG_PERIOD = 2'd2;
  localparam logic [1:0] CMD_UNREG      = 2'd3;

  localparam logic KIND_FIRED   = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  localparam logic [2:0] OP_HOLD    = 3'd0;
  localparam logic [2:0] OP_KILL    = 3'd1;
  localparam logic [2:0] OP_COMPACT = 3'd2;
  localparam logic [2:0] OP_MARK    = 3'd3;
  localparam logic [2:0] OP_POP     = 3'd4;
  localparam logic [2:0] OP_INSERT  = 3'd5;

  typedef struct packed {
    logic                    valid;
    logic                    due;
    logic                    single;
    logic [ClientIdBits-1:0] client;
    logic [TimeBits-1:0]     dl;
    logic [TimeBits-1:0]     iv;
  } entry_t;

  typedef struct packed {
    logic [2:0]              op;
    entry_t                  new_ent;
    logic [ClientIdBits-1:0] kill_id;
    logic [TimeBits-1:0]     now;
  } ctl_t;

endpackage

`default_nettype wire

/* design/stq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// One slot of the deadline-sorted chain; trades entries with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire stq_pkg::ctl_t   ctl_i,
  input  wire stq_pkg::entry_t prev_i,
  input  wire logic          prev_after_i,
  input  wire stq_pkg::entry_t next_i,
  input  wire logic          hole_i,
  output stq_pkg::entry_t    ent_o,
  output logic               after_o,
  output logic               hole_o
);
  import stq_pkg::*;

  entry_t ent_q, ent_d;

  // The new entry lands after every due entry and after equal deadlines.
  assign after_o = ent_q.valid && (ent_q.due || (ent_q.dl <= ctl_i.new_ent.dl));
  assign hole_o  = hole_i || !ent_q.valid;
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    unique case (ctl_i.op)
      OP_KILL: begin
        if (ent_q.client == ctl_i.kill_id) ent_d.valid = 1'b0;
      end
      OP_COMPACT: begin
        if (hole_o) ent_d = next_i;
      end
      OP_MARK: begin
        ent_d.due = ent_q.valid && (ent_q.dl <= ctl_i.now);
      end
      OP_POP: begin
        ent_d = next_i;
      end
      OP_INSERT: begin
        if (!after_o) ent_d = prev_after_i ? ctl_i.new_ent : prev_i;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

`default_nettype wire

/* design/sorted_timer_queue.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer list with one-shot and periodic clients kept in a sorted cell chain.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  command   start / busy                  cmd_i, client_id_i, interval_ticks_i
//  result    result_valid_o (one cycle)    kind_o, fired_id_o, fire_time_o, last_o
//
// A register or unregister that is dropped passes through the flush state.
// A tick walks its states in order: a kill step per queued remove, compaction
// until no gap is left (skipped without removes), mark, a fire step per fired
// entry with a re-arm slot after each periodic one, a merge step per queued
// add (skipped without adds), and flush.
// Reset empties every store; results cannot be stalled by the receiver.
`default_nettype none
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [stq_pkg::ClientIdBits-1:0] client_id_i,
  input  wire logic [stq_pkg::TimeBits-1:0]  interval_ticks_i,
  output logic                               result_valid_o,
  output logic                               kind_o,
  output logic [stq_pkg::ClientIdBits-1:0]   fired_id_o,
  output logic [stq_pkg::TimeBits-1:0]       fire_time_o,
  output logic                               last_o
);
  import stq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_KILL    = 3'd1;
  localparam logic [2:0] S_COMPACT = 3'd2;
  localparam logic [2:0] S_MARK    = 3'd3;
  localparam logic [2:0] S_FIRE    = 3'd4;
  localparam logic [2:0] S_REARM   = 3'd5;
  localparam logic [2:0] S_MERGE   = 3'd6;
  localparam logic [2:0] S_FLUSH   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [TimeBits-1:0] now_q, now_d;
  logic [AddCntW-1:0]  add_cnt_q, add_cnt_d;
  logic [RmCntW-1:0]   rm_cnt_q, rm_cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  entry_t              rearm_q, rearm_d;

  logic                    held_v_q, held_v_d;
  logic                    held_kind_q, held_kind_d;
  logic [ClientIdBits-1:0] held_id_q, held_id_d;
  logic [TimeBits-1:0]     held_time_q, held_time_d;

  logic                    out_v_q, out_v_d;
  logic                    out_kind_q, out_kind_d;
  logic [ClientIdBits-1:0] out_id_q, out_id_d;
  logic [TimeBits-1:0]     out_time_q, out_time_d;
  logic                    out_last_q, out_last_d;

  logic [TimeBits-1:0]     pa_dl_q     [PendAddDepth];
  logic [TimeBits-1:0]     pa_iv_q     [PendAddDepth];
  logic [ClientIdBits-1:0] pa_client_q [PendAddDepth];
  logic                    pa_single_q [PendAddDepth];
  logic [ClientIdBits-1:0] rm_client_q [PendRmDepth];

  logic                pa_we, rm_we;
  logic [TimeBits-1:0] iv_fix;
  logic                prod_v, prod_kind;
  logic [ClientIdBits-1:0] prod_id;

  ctl_t   ctl;
  entry_t ent   [ActiveDepth];
  logic   after [ActiveDepth];
  logic   hole  [ActiveDepth];
  logic   gap, full;

  logic [TimeBits-1:0] m_dl, m_iv;
  logic                m_single;
  logic [ClientIdBits-1:0] m_client;

  // Cell chain: each cell sees only its two neighbors.
  for (genvar i = 0; i < ActiveDepth; i++) begin : g_cell
    entry_t prev_w, next_w;
    logic   prev_after_w, hole_in_w;
    if (i == 0) begin : g_head
      assign prev_w       = '0;
      assign prev_after_w = 1'b1;
      assign hole_in_w    = 1'b0;
    end else begin : g_body
      assign prev_w       = ent[i-1];
      assign prev_after_w = after[i-1];
      assign hole_in_w    = hole[i-1];
    end
    if (i == ActiveDepth - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_mid
      assign next_w = ent[i+1];
    end
    stq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_i       (prev_w),
      .prev_after_i (prev_after_w),
      .next_i       (next_w),
      .hole_i       (hole_in_w),
      .ent_o        (ent[i]),
      .after_o      (after[i]),
      .hole_o       (hole[i])
    );
  end

  // A gap is a valid entry that sits behind an empty slot.
  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < ActiveDepth - 1; i++) begin
      if (!ent[i].valid && ent[i+1].valid) gap = 1'b1;
    end
  end

  assign full   = ent[ActiveDepth-1].valid;
  assign busy   = (state_q != S_IDLE);
  assign iv_fix = (interval_ticks_i == '0) ? TimeBits'(1) : interval_ticks_i;

  assign m_dl     = pa_dl_q[idx_q[AddIdxW-1:0]];
  assign m_iv     = pa_iv_q[idx_q[AddIdxW-1:0]];
  assign m_single = pa_single_q[idx_q[AddIdxW-1:0]];
  assign m_client = pa_client_q[idx_q[AddIdxW-1:0]];

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    add_cnt_d = add_cnt_q;
    rm_cnt_d  = rm_cnt_q;
    idx_d     = idx_q;
    rearm_d   = rearm_q;
    pa_we     = 1'b0;
    rm_we     = 1'b0;
    prod_v    = 1'b0;
    prod_kind = KIND_FIRED;
    prod_id   = '0;

    ctl         = '0;
    ctl.op      = OP_HOLD;
    ctl.now     = now_q;
    ctl.kill_id = rm_client_q[idx_q[RmIdxW-1:0]];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            CMD_TICK: begin
              now_d = now_q + TimeBits'(1);
              idx_d = '0;
              state_d = (rm_cnt_q != '0) ? S_KILL : S_MARK;
            end
            CMD_UNREG: begin
              if (rm_cnt_q < RmCntW'(PendRmDepth)) begin
                rm_we    = 1'b1;
                rm_cnt_d = rm_cnt_q + RmCntW'(1);
              end else begin
                prod_v    = 1'b1;
                prod_kind = KIND_DROPPED;
                prod_id   = client_id_i;
                state_d   = S_FLUSH;
              end
            end
            default: begin
              if (add_cnt_q < AddCntW'(PendAddDepth)) begin
                pa_we     = 1'b1;
                add_cnt_d = add_cnt_q + AddCntW'(1);
              end else begin
                prod_v    = 1'b1;
                prod_kind = KIND_DROPPED;
                prod_id   = client_id_i;
                state_d   = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_KILL: begin
        ctl.op = OP_KILL;
        if (RmCntW'(idx_q) + RmCntW'(1) == rm_cnt_q) begin
          rm_cnt_d = '0;
          state_d  = S_COMPACT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_COMPACT: begin
        if (gap) ctl.op = OP_COMPACT;
        else     state_d = S_MARK;
      end
      S_MARK: begin
        ctl.op  = OP_MARK;
        state_d = S_FIRE;
      end
      S_FIRE: begin
        if (ent[0].valid && ent[0].due) begin
          ctl.op  = OP_POP;
          prod_v  = 1'b1;
          prod_id = ent[0].client;
          if (!ent[0].single) begin
            rearm_d        = '0;
            rearm_d.valid  = 1'b1;
            rearm_d.client = ent[0].client;
            rearm_d.iv     = ent[0].iv;
            rearm_d.dl     = now_q + ent[0].iv;
            state_d        = S_REARM;
          end
        end else begin
          idx_d   = '0;
          state_d = (add_cnt_q != '0) ? S_MERGE : S_FLUSH;
        end
      end
      S_REARM: begin
        ctl.op      = OP_INSERT;
        ctl.new_ent = rearm_q;
        state_d     = S_FIRE;
      end
      S_MERGE: begin
        ctl.new_ent.valid  = 1'b1;
        ctl.new_ent.client = m_client;
        ctl.new_ent.iv     = m_iv;
        prod_id            = m_client;
        if (m_dl < now_q) begin
          // A passed entry fires now; a periodic one is re-armed from now, or dropped when the chain is full.
          ctl.new_ent.dl = now_q + m_iv;
          if (m_single) begin
            prod_v = 1'b1;
          end else if (full) begin
            prod_v    = 1'b1;
            prod_kind = KIND_DROPPED;
          end else begin
            ctl.op = OP_INSERT;
            prod_v = 1'b1;
          end
        end else begin
          ctl.new_ent.dl     = m_dl;
          ctl.new_ent.single = m_single;
          if (full) begin
            prod_v    = 1'b1;
            prod_kind = KIND_DROPPED;
          end else begin
            ctl.op = OP_INSERT;
          end
        end
        if (AddCntW'(idx_q) + AddCntW'(1) == add_cnt_q) begin
          add_cnt_d = '0;
          state_d   = S_FLUSH;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_FLUSH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // One result is held back so that the final one can carry the last flag.
  always_comb begin
    held_v_d    = held_v_q;
    held_kind_d = held_kind_q;
    held_id_d   = held_id_q;
    held_time_d = held_time_q;
    out_v_d     = 1'b0;
    out_kind_d  = held_kind_q;
    out_id_d    = held_id_q;
    out_time_d  = held_time_q;
    out_last_d  = 1'b0;
    if (prod_v) begin
      out_v_d     = held_v_q;
      held_v_d    = 1'b1;
      held_kind_d = prod_kind;
      held_id_d   = prod_id;
      held_time_d = now_q;
    end else if (state_q == S_FLUSH) begin
      out_v_d    = held_v_q;
      out_last_d = 1'b1;
      held_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      add_cnt_q <= '0;
      rm_cnt_q  <= '0;
      idx_q     <= '0;
      held_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      add_cnt_q <= add_cnt_d;
      rm_cnt_q  <= rm_cnt_d;
      idx_q     <= idx_d;
      held_v_q  <= held_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rearm_q     <= rearm_d;
    held_kind_q <= held_kind_d;
    held_id_q   <= held_id_d;
    held_time_q <= held_time_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_time_q  <= out_time_d;
    out_last_q  <= out_last_d;
    if (pa_we) begin
      pa_dl_q[add_cnt_q[AddIdxW-1:0]]     <= now_q + iv_fix;
      pa_iv_q[add_cnt_q[AddIdxW-1:0]]     <= iv_fix;
      pa_client_q[add_cnt_q[AddIdxW-1:0]] <= client_id_i;
      pa_single_q[add_cnt_q[AddIdxW-1:0]] <= (cmd_i == CMD_REG_ONCE);
    end
    if (rm_we) begin
      rm_client_q[rm_cnt_q[RmIdxW-1:0]] <= client_id_i;
    end
  end

  assign result_valid_o = out_v_q;
  assign kind_o         = out_kind_q;
  assign fired_id_o     = out_id_q;
  assign fire_time_o    = out_time_q;
  assign last_o         = out_last_q;

  `STQ_ASSERT(a_res_from_work, clk_i, rst_ni, out_v_q |-> $past(state_q != S_IDLE), "result outside a command")
  `STQ_ASSERT(a_rearm_room, clk_i, rst_ni, (state_q == S_REARM) |-> !full, "re-arm into a full chain")
  `STQ_ASSERT_NEXT(a_flush_idle, clk_i, rst_ni, state_q == S_FLUSH, (state_q == S_IDLE) && !held_v_q, "flush left a result behind")
  `STQ_ASSERT(a_add_bound, clk_i, rst_ni, add_cnt_q <= AddCntW'(PendAddDepth), "pending add count overflow")

endmodule

`default_nettype wire

/* test/tb_sorted_timer_queue.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives register, unregister and tick commands with random gaps. A local
// timer list model predicts every fired or dropped word, and the monitor
// checks each result word field by field in order.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  id;
    logic [31:0] iv;
    bit          hold;
    bit          nogap;
  } cmd_item_t;

  typedef struct {
    logic [31:0] dl;
    logic [31:0] iv;
    logic [7:0]  id;
    logic        once;
  } timer_t;

  typedef struct {
    logic        kind;
    logic [7:0]  id;
    logic [31:0] t;
    logic        last;
  } fire_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd_i = CMD_TICK;
  logic [7:0]  client_id_i = '0;
  logic [31:0] interval_ticks_i = '0;
  logic        result_valid_o, kind_o, last_o;
  logic [7:0]  fired_id_o;
  logic [31:0] fire_time_o;

  cmd_item_t   cmd_q[$];
  fire_t       due_q[$];
  timer_t      active_list[$];
  timer_t      add_list[$];
  logic [7:0]  remove_list[$];
  logic [31:0] now_t = '0;
  int          errors = 0;

  sorted_timer_queue DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic void add_cmd(logic [1:0] c, logic [7:0] id, logic [31:0] iv,
                                  bit hold = 0, bit nogap = 0);
    cmd_item_t it;
    it.cmd = c; it.id = id; it.iv = iv; it.hold = hold; it.nogap = nogap;
    cmd_q = {cmd_q, it};
  endfunction

  function automatic void note_fire(logic kind, logic [7:0] id);
    fire_t f;
    f.kind = kind; f.id = id; f.t = now_t; f.last = 1'b0;
    due_q = {due_q, f};
  endfunction

  // Sorted insert after equal deadlines; fails when the table is full.
  function automatic bit arm_timer(timer_t e);
    int pos = 0;
    if (active_list.size() >= ActiveDepth) return 0;
    while (pos < active_list.size() && active_list[pos].dl <= e.dl) pos++;
    active_list.insert(pos, e);
    return 1;
  endfunction

  function automatic void timer_step(logic [1:0] c, logic [7:0] id, logic [31:0] iv);
    int     n0 = due_q.size();
    timer_t e;
    timer_t kept[$];
    timer_t fired[$];
    if (c == CMD_TICK) begin
      now_t = now_t + 1;
      foreach (remove_list[r]) begin
        kept.delete();
        foreach (active_list[i]) if (active_list[i].id != remove_list[r])
          kept = {kept, active_list[i]};
        active_list = kept;
      end
      remove_list.delete();
      while (active_list.size() > 0 && active_list[0].dl <= now_t)
        fired = {fired, active_list.pop_front()};
      foreach (fired[i]) begin
        note_fire(KIND_FIRED, fired[i].id);
        if (!fired[i].once) begin
          e = fired[i];
          e.dl = now_t + e.iv;
          void'(arm_timer(e));
        end
      end
      foreach (add_list[i]) begin
        e = add_list[i];
        if (e.dl < now_t) begin
          if (e.once) note_fire(KIND_FIRED, e.id);
          else begin
            e.dl = now_t + e.iv;
            note_fire(arm_timer(e) ? KIND_FIRED : KIND_DROPPED, e.id);
          end
        end else if (!arm_timer(e)) begin
          note_fire(KIND_DROPPED, e.id);
        end
      end
      add_list.delete();
    end else if (c == CMD_UNREG) begin
      if (remove_list.size() < PendRmDepth) remove_list = {remove_list, id};
      else note_fire(KIND_DROPPED, id);
    end else begin
      if (iv == 0) iv = 1;
      if (add_list.size() < PendAddDepth) begin
        e.dl = now_t + iv; e.iv = iv; e.id = id; e.once = (c == CMD_REG_ONCE);
        add_list = {add_list, e};
      end else begin
        note_fire(KIND_DROPPED, id);
      end
    end
    if (due_q.size() > n0) due_q[due_q.size()-1].last = 1'b1;
  endfunction

  // Driver: the front item is held back when it asks for a drained result queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) timer_step(cmd_i, client_id_i, interval_ticks_i);
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && !(cmd_q[0].hold && due_q.size() > 0) &&
            (cmd_q[0].nogap || $urandom_range(99) >= 9)) begin
          cmd_item_t it;
          it = cmd_q.pop_front();
          start <= 1'b1;
          cmd_i <= it.cmd;
          client_id_i <= it.id;
          interval_ticks_i <= it.iv;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (due_q.size() == 0) begin
        $error("unexpected result word: id %0d time %0d", fired_id_o, fire_time_o);
        errors++;
      end else begin
        fire_t f;
        f = due_q.pop_front();
        if (kind_o !== f.kind) begin
          $error("kind: expected %0d, got %0d", f.kind, kind_o); errors++;
        end
        if (fired_id_o !== f.id) begin
          $error("fired_id: expected %0d, got %0d", f.id, fired_id_o); errors++;
        end
        if (fire_time_o !== f.t) begin
          $error("fire_time: expected %0d, got %0d", f.t, fire_time_o); errors++;
        end
        if (last_o !== f.last) begin
          $error("last: expected %0d, got %0d", f.last, last_o); errors++;
        end
      end
    end
  end

  initial begin
    logic [1:0]  c;
    logic [31:0] iv;
    int          w;
    // Directed part: interval extremes, id extremes, periodic rearm and purge.
    add_cmd(CMD_REG_ONCE, 8'd0, 32'd0);
    add_cmd(CMD_TICK, 0, 0); add_cmd(CMD_TICK, 0, 0);
    add_cmd(CMD_REG_PERIOD, 8'd255, 32'd1);
    add_cmd(CMD_TICK, 0, 0); add_cmd(CMD_TICK, 0, 0); add_cmd(CMD_TICK, 0, 0);
    add_cmd(CMD_UNREG, 8'd255, 32'hFFFF_FFFF);
    add_cmd(CMD_TICK, 0, 0);
    // A full-scale interval wraps to a deadline already passed at merge.
    add_cmd(CMD_REG_ONCE, 8'h5A, 32'hFFFF_FFFF);
    add_cmd(CMD_REG_PERIOD, 8'hA5, 32'hFFFF_FFFF);
    add_cmd(CMD_TICK, 0, 0); add_cmd(CMD_TICK, 0, 0);
    add_cmd(CMD_UNREG, 8'hA5, 0);
    add_cmd(CMD_TICK, 0, 0);
    // Duplicate registrations, then an unregister of an unknown id.
    add_cmd(CMD_REG_ONCE, 8'd7, 32'd2); add_cmd(CMD_REG_PERIOD, 8'd7, 32'd2);
    add_cmd(CMD_UNREG, 8'd7, 0); add_cmd(CMD_UNREG, 8'd200, 0);
    add_cmd(CMD_TICK, 0, 0);
    // Overflow of both pending buffers.
    for (int i = 0; i < 9; i++) add_cmd(CMD_REG_ONCE, 8'(40 + i), 32'd3);
    for (int i = 0; i < 9; i++) add_cmd(CMD_UNREG, 8'(60 + i), 0);
    add_cmd(CMD_TICK, 0, 0);
    // Fill the active table past its depth; these expire after about 30 ticks.
    for (int r = 0; r < 5; r++) begin
      for (int i = 0; i < 8; i++) add_cmd(CMD_REG_ONCE, 8'(100 + 8*r + i), 32'd30, r == 0);
      add_cmd(CMD_TICK, 0, 0);
    end
    for (int i = 0; i < 330; i++) begin
      w = $urandom_range(99);
      c = (w < 45) ? CMD_TICK : (w < 68) ? CMD_REG_ONCE : (w < 85) ? CMD_REG_PERIOD
                                                             : CMD_UNREG;
      w = $urandom_range(99);
      iv = (w < 70) ? 32'($urandom_range(1, 12)) : (w < 80) ? 32'd0 :
           (w < 90) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
      add_cmd(c, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)), iv,
              i == 0 || i == 200, i >= 120 && i < 220);
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (cmd_q.size() > 0 || start) @(posedge clk_i);
    while (due_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && due_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
